/* src/sc2cal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2cal_pkg
// Shared types and constants of the seconds-count to calendar converter.
// ----------------------------------------------------------------------------
package sc2cal_pkg;

    localparam int NUM_STAGES = 6;

    // Per-stage load enables, index 0 is the first register stage.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctl_t;

    // Selects which 400-year cycle count applies (67, 68 or 69).
    typedef logic [1:0] cent_sel_t;

    // Epoch and Richards/Fliegel constants.
    localparam int JDN_EPOCH  = 2440588;
    localparam int JDN_OFFSET = 32044;
    localparam int DAYS_400Y  = 146097;
    localparam int DAYS_4Y    = 1461;
    localparam int YEAR_BIAS  = 4800;
    localparam int CENT_FIRST = 67;

    // Exact reciprocals for division by constants over the value ranges in use.
    localparam logic [25:0] RECIP_675  = 26'd50903317;  // ceil(2^35 / 675)
    localparam int          SHIFT_675  = 35;
    localparam logic [16:0] RECIP_7    = 17'd74899;     // ceil(2^19 / 7)
    localparam int          SHIFT_7    = 19;
    localparam logic [18:0] RECIP_60A  = 19'd279621;    // ceil(2^24 / 60)
    localparam int          SHIFT_60A  = 24;
    localparam logic [12:0] RECIP_60B  = 13'd4370;      // ceil(2^18 / 60)
    localparam int          SHIFT_60B  = 18;
    localparam logic [19:0] RECIP_1461 = 20'd734937;    // ceil(2^30 / 1461)
    localparam int          SHIFT_1461 = 30;
    localparam logic [12:0] RECIP_153  = 13'd6854;      // ceil(2^20 / 153)
    localparam int          SHIFT_153  = 20;

    localparam logic [21:0] A_OFFSET = 22'(JDN_EPOCH + JDN_OFFSET);
    localparam logic [23:0] CENT_TH1 = 24'(DAYS_400Y * (CENT_FIRST + 1));
    localparam logic [23:0] CENT_TH2 = 24'(DAYS_400Y * (CENT_FIRST + 2));
    localparam logic [21:0] CENT_BASE0 = 22'((DAYS_400Y * CENT_FIRST) / 4);
    localparam logic [21:0] CENT_BASE1 = 22'((DAYS_400Y * (CENT_FIRST + 1)) / 4);
    localparam logic [21:0] CENT_BASE2 = 22'((DAYS_400Y * (CENT_FIRST + 2)) / 4);
    localparam logic [11:0] YEAR_BASE0 = 12'(100 * CENT_FIRST - YEAR_BIAS);
    localparam logic [11:0] YEAR_BASE1 = 12'(100 * (CENT_FIRST + 1) - YEAR_BIAS);
    localparam logic [11:0] YEAR_BASE2 = 12'(100 * (CENT_FIRST + 2) - YEAR_BIAS);
    localparam int          WEEK_OFFSET = JDN_EPOCH % 7;

    localparam cent_sel_t CENT_SEL0 = 2'd0;
    localparam cent_sel_t CENT_SEL1 = 2'd1;
    localparam cent_sel_t CENT_SEL2 = 2'd2;

    // Day-of-year offset of a March-based month: (153 * mm + 2) / 5.
    function automatic logic [8:0] month_start(input logic [3:0] mm);
        logic [8:0] r;
        case (mm)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

/* src/sc2cal_days.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2cal_days
// Splits the seconds count into a day count and the second of the day, and
// prepares the century selection and the weekday quotient.
// ----------------------------------------------------------------------------
module sc2cal_days (
    input  logic                   aclk,
    input  sc2cal_pkg::stage_ctl_t ctl,
    input  logic [31:0]            seconds_count,
    output logic [16:0]            tod,
    output logic [15:0]            days,
    output logic [14:0]            week_quot,
    output sc2cal_pkg::cent_sel_t  cent_sel,
    output logic [15:0]            cent_rem
);
    import sc2cal_pkg::*;

    logic [15:0] days1_reg;
    logic [16:0] slo1_reg;
    logic [16:0] tod2_reg;
    logic [15:0] days2_reg;
    logic [14:0] wq2_reg;
    cent_sel_t   ci2_reg;
    logic [15:0] c2_reg;

    logic [50:0] day_prod;
    logic [32:0] day_secs;
    logic [16:0] day_w;
    logic [33:0] week_prod;
    logic [21:0] a_val;
    logic [23:0] a_x4;
    cent_sel_t   ci_next;
    logic [21:0] base;
    logic [21:0] c_full;

    // 86400 = 128 * 675, so the low seven bits drop out before the reciprocal.
    assign day_prod = seconds_count[31:7] * RECIP_675;

    always_comb begin
        day_secs  = {1'b0, days1_reg} * 17'd86400;
        day_w     = {1'b0, days1_reg} + 17'(WEEK_OFFSET);
        week_prod = day_w * RECIP_7;
        a_val     = {6'd0, days1_reg} + A_OFFSET;
        a_x4      = {a_val, 2'b11};
        if (a_x4 >= CENT_TH2) begin
            ci_next = CENT_SEL2;
        end else if (a_x4 >= CENT_TH1) begin
            ci_next = CENT_SEL1;
        end else begin
            ci_next = CENT_SEL0;
        end
        case (ci_next)
            CENT_SEL0: base = CENT_BASE0;
            CENT_SEL1: base = CENT_BASE1;
            CENT_SEL2: base = CENT_BASE2;
            default:   base = CENT_BASE0;
        endcase
        c_full = a_val - base;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            days1_reg <= day_prod[SHIFT_675 +: 16];
            slo1_reg  <= seconds_count[16:0];
        end
        if (ctl.load[1]) begin
            tod2_reg  <= slo1_reg - day_secs[16:0];
            days2_reg <= days1_reg;
            wq2_reg   <= week_prod[SHIFT_7 +: 15];
            ci2_reg   <= ci_next;
            c2_reg    <= c_full[15:0];
        end
    end

    assign tod       = tod2_reg;
    assign days      = days2_reg;
    assign week_quot = wq2_reg;
    assign cent_sel  = ci2_reg;
    assign cent_rem  = c2_reg;

endmodule

/* src/sc2cal_tod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2cal_tod
// Breaks the second of the day into hour, minute and second.
// ----------------------------------------------------------------------------
module sc2cal_tod (
    input  logic                   aclk,
    input  sc2cal_pkg::stage_ctl_t ctl,
    input  logic [16:0]            tod,
    output logic [5:0]             second,
    output logic [5:0]             minute,
    output logic [4:0]             hour
);
    import sc2cal_pkg::*;

    logic [16:0] tod3_reg;
    logic [10:0] mt3_reg;
    logic [10:0] mt4_reg;
    logic [5:0]  sec4_reg;
    logic [4:0]  hr4_reg;
    logic [5:0]  sec5_reg;
    logic [5:0]  min5_reg;
    logic [4:0]  hr5_reg;
    logic [5:0]  sec6_reg;
    logic [5:0]  min6_reg;
    logic [4:0]  hr6_reg;

    logic [35:0] mt_prod;
    logic [16:0] mt_x60;
    logic [16:0] sec_full;
    logic [23:0] hr_prod;
    logic [10:0] hr_x60;
    logic [10:0] min_full;

    always_comb begin
        mt_prod  = tod * RECIP_60A;
        mt_x60   = {mt3_reg, 6'd0} - {4'd0, mt3_reg, 2'd0};
        sec_full = tod3_reg - mt_x60;
        hr_prod  = mt3_reg * RECIP_60B;
        hr_x60   = {hr4_reg, 6'd0} - {4'd0, hr4_reg, 2'd0};
        min_full = mt4_reg - hr_x60;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            tod3_reg <= tod;
            mt3_reg  <= mt_prod[SHIFT_60A +: 11];
        end
        if (ctl.load[3]) begin
            mt4_reg  <= mt3_reg;
            sec4_reg <= sec_full[5:0];
            hr4_reg  <= hr_prod[SHIFT_60B +: 5];
        end
        if (ctl.load[4]) begin
            sec5_reg <= sec4_reg;
            min5_reg <= min_full[5:0];
            hr5_reg  <= hr4_reg;
        end
        if (ctl.load[5]) begin
            sec6_reg <= sec5_reg;
            min6_reg <= min5_reg;
            hr6_reg  <= hr5_reg;
        end
    end

    assign second = sec6_reg;
    assign minute = min6_reg;
    assign hour   = hr6_reg;

endmodule

/* src/sc2cal_date.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2cal_date
// Gregorian date and weekday from the day count, Richards/Fliegel steps.
// ----------------------------------------------------------------------------
module sc2cal_date (
    input  logic                   aclk,
    input  sc2cal_pkg::stage_ctl_t ctl,
    input  logic [15:0]            days,
    input  logic [14:0]            week_quot,
    input  sc2cal_pkg::cent_sel_t  cent_sel,
    input  logic [15:0]            cent_rem,
    output logic [2:0]             weekday,
    output logic [4:0]             day_of_month,
    output logic [3:0]             month,
    output logic [11:0]            year
);
    import sc2cal_pkg::*;

    logic [2:0]  wd3_reg;
    cent_sel_t   ci3_reg;
    logic [15:0] c3_reg;
    logic [7:0]  yq3_reg;
    logic [2:0]  wd4_reg;
    cent_sel_t   ci4_reg;
    logic [7:0]  yq4_reg;
    logic [8:0]  e4_reg;
    logic [2:0]  wd5_reg;
    cent_sel_t   ci5_reg;
    logic [7:0]  yq5_reg;
    logic [8:0]  e5_reg;
    logic [3:0]  mm5_reg;
    logic [2:0]  wd6_reg;
    logic [4:0]  mday6_reg;
    logic [3:0]  mon6_reg;
    logic [11:0] yr6_reg;

    logic [16:0] wk_x7;
    logic [16:0] wk_rem;
    logic [37:0] yq_prod;
    logic [17:0] yq_days;
    logic [15:0] e_full;
    logic [10:0] e_x5;
    logic [23:0] mm_prod;
    logic        wrap;
    logic [8:0]  mday_full;
    logic [11:0] ybase;

    always_comb begin
        wk_x7     = 17'({week_quot, 3'd0} - {3'd0, week_quot});
        wk_rem    = ({1'b0, days} + 17'(WEEK_OFFSET)) - wk_x7;
        yq_prod   = {cent_rem, 2'b11} * RECIP_1461;
        yq_days   = yq3_reg * 11'(DAYS_4Y);
        e_full    = c3_reg - yq_days[17:2];
        e_x5      = {e4_reg, 2'd0} + {2'd0, e4_reg} + 11'd2;
        mm_prod   = e_x5 * RECIP_153;
        // March-based months ten and eleven are January and February.
        wrap      = (mm5_reg >= 4'd10);
        mday_full = e5_reg - month_start(mm5_reg) + 9'd1;
        case (ci5_reg)
            CENT_SEL0: ybase = YEAR_BASE0;
            CENT_SEL1: ybase = YEAR_BASE1;
            CENT_SEL2: ybase = YEAR_BASE2;
            default:   ybase = YEAR_BASE0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            wd3_reg <= wk_rem[2:0];
            ci3_reg <= cent_sel;
            c3_reg  <= cent_rem;
            yq3_reg <= yq_prod[SHIFT_1461 +: 8];
        end
        if (ctl.load[3]) begin
            wd4_reg <= wd3_reg;
            ci4_reg <= ci3_reg;
            yq4_reg <= yq3_reg;
            e4_reg  <= e_full[8:0];
        end
        if (ctl.load[4]) begin
            wd5_reg <= wd4_reg;
            ci5_reg <= ci4_reg;
            yq5_reg <= yq4_reg;
            e5_reg  <= e4_reg;
            mm5_reg <= mm_prod[SHIFT_153 +: 4];
        end
        if (ctl.load[5]) begin
            wd6_reg   <= wd5_reg;
            mday6_reg <= mday_full[4:0];
            mon6_reg  <= wrap ? (mm5_reg - 4'd9) : (mm5_reg + 4'd3);
            yr6_reg   <= ybase + {4'd0, yq5_reg} + {11'd0, wrap};
        end
    end

    assign weekday      = wd6_reg;
    assign day_of_month = mday6_reg;
    assign month        = mon6_reg;
    assign year         = yr6_reg;

endmodule

/* src/seconds_count_to_calendar.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_count_to_calendar
// Converts a seconds count since 1970-01-01 00:00:00 into time and date.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one item per transfer: the 32-bit seconds count in
// s_tdata. The master channel returns one item for each input item, in order:
// second, minute, hour, weekday (0 is Monday), day of month, month and year
// packed into m_tdata.
// The converter is a six-stage pipeline. One item is taken every cycle
// as long as the master side keeps up. The stage count is set by the chain
// of constant-reciprocal multiplications in the date path, each followed by
// a register.
// When the receiver holds m_tready low, the result stays on m_tdata and the
// pipeline keeps filling empty stages; s_tready falls only once every stage
// holds an item. Nothing is dropped or repeated.
// Reset clears all stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module seconds_count_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seconds_count
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
    // [24:20] day_of_month, [28:25] month, [40:29] year, [47:41] zero
    output logic [47:0] m_tdata
);
    import sc2cal_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    stage_ctl_t            ctl;

    logic [16:0] tod;
    logic [15:0] days;
    logic [14:0] week_quot;
    cent_sel_t   cent_sel;
    logic [15:0] cent_rem;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        ctl.load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            ctl.load[i] = !valid_reg[i] || ctl.load[i+1];
        end
        valid_next = valid_reg;
        if (ctl.load[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (ctl.load[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    sc2cal_days u_days (
        .aclk          (aclk),
        .ctl           (ctl),
        .seconds_count (s_tdata),
        .tod           (tod),
        .days          (days),
        .week_quot     (week_quot),
        .cent_sel      (cent_sel),
        .cent_rem      (cent_rem)
    );

    sc2cal_tod u_tod (
        .aclk   (aclk),
        .ctl    (ctl),
        .tod    (tod),
        .second (second),
        .minute (minute),
        .hour   (hour)
    );

    sc2cal_date u_date (
        .aclk         (aclk),
        .ctl          (ctl),
        .days         (days),
        .week_quot    (week_quot),
        .cent_sel     (cent_sel),
        .cent_rem     (cent_rem),
        .weekday      (weekday),
        .day_of_month (day_of_month),
        .month        (month),
        .year         (year)
    );

    assign s_tready = ctl.load[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {7'd0, year, month, day_of_month, weekday, hour, minute, second};

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24)
                     && (weekday < 3'd7))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (day_of_month != 5'd0) && (month != 4'd0) && (month <= 4'd12)
                     && (year >= 12'd1970) && (year <= 12'd2106))
        else $error("calendar date out of range");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (valid_reg == '1) && !m_tready)
        else $error("input stalled while the pipeline has room");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the seconds-count to calendar converter.
// Every accepted seconds count is converted to a date and time of day by an
// independent integer conversion in the testbench. The expected dates wait
// in order and are compared field by field with each item on the master
// side. Directed counts at the edges of the range and at month, year and
// leap-day boundaries come first. Random counts then run under several
// sender and receiver idling mixes, and a long receiver hold-off makes the
// pipeline fill up and stall its input.
// ----------------------------------------------------------------------------
module tb;

    localparam longint unsigned SECS_PER_DAY = 86400;
    localparam longint unsigned JD_UNIX_EPOCH = 2440588;
    localparam longint unsigned JD_SHIFT = 32044;
    localparam longint unsigned GREG_CYCLE_DAYS = 146097;
    localparam longint unsigned JULIAN_CYCLE_DAYS = 1461;
    localparam longint unsigned MARCH_YEAR_SPAN = 153;
    localparam longint unsigned YEAR_SHIFT = 4800;
    localparam int unsigned LAST_FULL_DAY = 49709;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    // Result layout from the lowest bit up: second, minute, hour, weekday,
    // day of month, month, year and the zero fill.
    typedef struct packed {
        logic [6:0]  fill;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    calendar_t pending_dates[$];
    int        mismatch_count = 0;
    int        orphan_count = 0;
    int        quiet_cycles = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        hold_request = 0;
    int        hold_left = 0;

    seconds_count_to_calendar DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Julian day number first, then the Gregorian date by integer arithmetic.
    function automatic calendar_t calendar_of(input logic [31:0] secs);
        longint unsigned days, tod, jdn, a, cent, c, yq, e, mm, wrap;
        calendar_t r;
        days = longint'(secs) / SECS_PER_DAY;
        tod  = longint'(secs) - days * SECS_PER_DAY;
        jdn  = days + JD_UNIX_EPOCH;
        a    = jdn + JD_SHIFT;
        cent = (4 * a + 3) / GREG_CYCLE_DAYS;
        c    = a - (GREG_CYCLE_DAYS * cent) / 4;
        yq   = (4 * c + 3) / JULIAN_CYCLE_DAYS;
        e    = c - (JULIAN_CYCLE_DAYS * yq) / 4;
        mm   = (5 * e + 2) / MARCH_YEAR_SPAN;
        wrap = mm / 10;
        r         = '0;
        r.second  = 6'(tod % 60);
        r.minute  = 6'((tod / 60) % 60);
        r.hour    = 5'(tod / 3600);
        r.weekday = 3'(jdn % 7);
        r.mday    = 5'(e - (MARCH_YEAR_SPAN * mm + 2) / 5 + 1);
        r.month   = 4'(mm + 3 - 12 * wrap);
        r.year    = 12'(100 * cent + yq + wrap - YEAR_SHIFT);
        return r;
    endfunction

    // Mostly uniform counts, with extra weight near midnight, near the top
    // of the range and in the first days after the epoch.
    function automatic logic [31:0] random_count();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1: begin
                v = 32'($urandom_range(LAST_FULL_DAY) * SECS_PER_DAY);
                case ($urandom_range(3))
                    0: v = v;
                    1: v = v + 32'd1;
                    2: v = v + 32'd86399;
                    default: v = v + 32'd43200;
                endcase
            end
            2: v = 32'hFFFF_FFFF - 32'($urandom_range(200000));
            3: v = 32'($urandom_range(200000));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Receiver: a requested hold-off is counted here, otherwise random stalls.
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Records accepted counts, checks results and watches for a hang.
    always @(posedge aclk) begin
        calendar_t got;
        calendar_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_dates.push_back(calendar_of(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = calendar_t'(m_tdata);
                if (pending_dates.size() == 0) begin
                    orphan_count++;
                    if (orphan_count + mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: result item with no count pending: %h", $realtime,
                                 m_tdata);
                    end
                end else begin
                    want = pending_dates.pop_front();
                    if (got.second !== want.second || got.minute !== want.minute ||
                        got.hour !== want.hour || got.weekday !== want.weekday ||
                        got.mday !== want.mday || got.month !== want.month ||
                        got.year !== want.year) begin
                        mismatch_count++;
                        if (orphan_count + mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: expected %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                                     $realtime, want.year, want.month, want.mday,
                                     want.hour, want.minute, want.second, want.weekday);
                            $display("%0t:      got %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                                     $realtime, got.year, got.month, got.mday,
                                     got.hour, got.minute, got.second, got.weekday);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // Offers one count, after a random gap, and returns at the accepting edge
    // with tvalid still high so that a following item goes out back to back.
    task automatic send_count(input logic [31:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
    endtask

    // The last item was accepted at the current edge; the task waits for the
    // checker to record it before the queue is looked at.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_dates.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        logic [31:0] counts[$];
        counts = {32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                  32'd86400,
                  32'd68169600,      // leap day of the first leap year
                  32'd946684799,     // last second of a century year's eve
                  32'd951782400,     // leap day of a year divisible by 400
                  32'd951868800,
                  32'd4107455999,    // a century year without a leap day
                  32'd4107542400,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'hFFFF_FFFF - 32'd43200, 32'hFFFF_FFFF - 32'd43199,
                  32'hFFFF_FFFE, 32'hFFFF_FFFF};
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        foreach (counts[i]) send_count(counts[i]);
        wait_all_results();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int n);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (n) send_count(random_count());
        wait_all_results();
    endtask

    // The receiver holds off while items keep coming, so the pipeline fills
    // and s_tready drops; the sender then stops until everything is back.
    task automatic test_hold_off();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (40) send_count(random_count());
        wait_all_results();
        tx_idle_pct  = 33;
        rx_stall_pct = 33;
        repeat (20) send_count(random_count());
        wait_all_results();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(0, 0, 440);
        test_random(68, 0, 440);
        test_random(0, 68, 440);
        test_random(33, 33, 440);
        test_hold_off();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && orphan_count == 0 && pending_dates.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
